/* hw/rtl/tss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the three-stack memory block.
// No dependencies; every other file imports this package.
package tss_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 7;

  // Capacity register value after reset, and the smallest usable capacity.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;
  localparam logic [CAP_BITS-1:0] MIN_CAP   = 7'd3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } tss_op_t;

  typedef enum logic [1:0] {
    SEL_FIRST   = 2'd0,
    SEL_SECOND  = 2'd1,
    SEL_MIDDLE  = 2'd2,
    SEL_INVALID = 2'd3
  } tss_sel_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } tss_status_t;

  // Per-cycle command broadcast along the row of storage cells.
  typedef struct packed {
    logic shift;
    logic shift_left;
    logic write;
    logic read;
  } tss_cell_ctrl_t;

endpackage

/* hw/rtl/tss_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on tss_pkg for the payload widths.
interface tss_req_if import tss_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [1:0]                   stack_sel;
  logic signed [VALUE_BITS-1:0] push_value;

  modport source (output valid, req_type, stack_sel, push_value, input ready);
  modport sink   (input valid, req_type, stack_sel, push_value, output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] pop_value;
  logic [1:0]                   status;

  modport source (output valid, pop_value, status, input ready);
  modport sink   (input valid, pop_value, status, output ready);
endinterface

/* hw/rtl/tss_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the shared stack memory: a word plus a read-chain stage.
// Depends on tss_pkg for the command struct.
module tss_cell import tss_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int CW        = 7,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  tss_cell_ctrl_t       ctrl,
  input  logic [CW-1:0]        shift_lo,
  input  logic [CW-1:0]        shift_end,
  input  logic [CW-1:0]        waddr,
  input  logic [CW-1:0]        raddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic [WORD_BITS-1:0] carry_in,
  output logic [WORD_BITS-1:0] word,
  output logic [WORD_BITS-1:0] carry
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic in_range;

  assign in_range = (IDX >= shift_lo) && (IDX < shift_end);

  // A shift takes the neighbor's word; a write loads the pushed word.
  always_ff @(posedge clk) begin
    if (ctrl.shift && in_range) begin
      word <= ctrl.shift_left ? right_word : left_word;
    end else if (ctrl.write && (waddr == IDX)) begin
      word <= wdata;
    end
  end

  // The addressed cell injects its word; every other cell passes its right
  // neighbor's carry one place toward cell zero.
  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      carry <= (raddr == IDX) ? word : carry_in;
    end
  end

endmodule

/* hw/rtl/three_stacks_shared_memory.sv */
`timescale 1ns / 1ps
// Three stacks in one shared word store built as a row of cells.
// A refused request goes straight to the response state; a push passes the write
// state, after the shift state if it moves the middle stack; a pop of entry k stays
// in the read state while the read chain walks it toward cell zero. One request is
// in flight at a time; the next transfer can be taken the cycle after the result
// transfer while cfg_we is low. Reset empties all stacks; stored words are undefined.
module three_stacks_shared_memory import tss_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata,
  tss_req_if.sink             req,
  tss_rsp_if.source           rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_WRITE,
    S_READ,
    S_RESP
  } state_t;

  function automatic logic [CW-1:0] eff_of(input logic [CAP_BITS-1:0] c);
    logic [EW-1:0] x;
    x = EW'(c);
    if (x < EW'(MIN_CAP)) x = EW'(MIN_CAP);
    if (x > EW'(DEPTH)) x = EW'(DEPTH);
    return CW'(x);
  endfunction

  state_t               state;
  logic [CAP_BITS-1:0]  cap;
  logic [CW-1:0]        first_count, second_count, middle_count, middle_base;
  logic [CW-1:0]        eff_cap;

  // Registered plan for the request in flight.
  logic                 plan_shift, plan_left, plan_write, plan_read;
  logic [CW-1:0]        plan_lo, plan_end, plan_waddr, plan_raddr, rd_cnt;
  logic [WORD_BITS-1:0] plan_word;
  tss_status_t          plan_status;

  // Decode of the incoming request.
  tss_status_t   status_next;
  logic          shift_next, left_next, write_next, read_next;
  logic [CW-1:0] lo_next, end_next, waddr_next, raddr_next;
  logic [CW-1:0] first_next, second_next, middle_next, base_next;
  logic [CW-1:0] total;
  logic          collide;
  logic          accept;

  tss_cell_ctrl_t       ctrl;
  logic [WORD_BITS-1:0] words  [DEPTH];
  logic [WORD_BITS-1:0] carries[DEPTH];

  assign eff_cap = eff_of(cap);
  assign total   = first_count + second_count + middle_count;
  assign collide = (middle_base + middle_count) == (eff_cap - second_count);
  assign accept  = req.valid && req.ready;

  always_comb begin
    status_next = ST_OK;
    shift_next  = 1'b0;
    left_next   = 1'b0;
    write_next  = 1'b0;
    read_next   = 1'b0;
    lo_next     = middle_base + CW'(1);
    end_next    = middle_base + middle_count + CW'(1);
    waddr_next  = first_count;
    raddr_next  = first_count - CW'(1);
    first_next  = first_count;
    second_next = second_count;
    middle_next = middle_count;
    base_next   = middle_base;
    if (req.stack_sel == SEL_INVALID) begin
      status_next = ST_INVALID;
    end else if (req.req_type == OP_PUSH) begin
      if (total >= eff_cap) begin
        status_next = ST_FULL;
      end else if (req.stack_sel == SEL_FIRST) begin
        write_next = 1'b1;
        first_next = first_count + CW'(1);
        if (first_count == middle_base) begin
          // The first stack has reached the middle one: move it right.
          shift_next = 1'b1;
          base_next  = middle_base + CW'(1);
        end
      end else begin
        write_next = 1'b1;
        if (collide) begin
          // The middle stack touches the second one: move it left.
          shift_next = 1'b1;
          left_next  = 1'b1;
          lo_next    = middle_base - CW'(1);
          end_next   = middle_base + middle_count - CW'(1);
          base_next  = middle_base - CW'(1);
        end
        if (req.stack_sel == SEL_SECOND) begin
          waddr_next  = eff_cap - CW'(1) - second_count;
          second_next = second_count + CW'(1);
        end else begin
          waddr_next  = base_next + middle_count;
          middle_next = middle_count + CW'(1);
        end
      end
    end else begin
      case (req.stack_sel)
        SEL_FIRST: begin
          if (first_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            read_next  = 1'b1;
            raddr_next = first_count - CW'(1);
            first_next = first_count - CW'(1);
          end
        end
        SEL_SECOND: begin
          if (second_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            read_next   = 1'b1;
            raddr_next  = eff_cap - second_count;
            second_next = second_count - CW'(1);
          end
        end
        SEL_MIDDLE: begin
          if (middle_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            read_next   = 1'b1;
            raddr_next  = middle_base + middle_count - CW'(1);
            middle_next = middle_count - CW'(1);
          end
        end
        default: begin
          status_next = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cap          <= CAP_RESET;
      first_count  <= '0;
      second_count <= '0;
      middle_count <= '0;
      middle_base  <= eff_of(CAP_RESET) >> 1;
      plan_shift   <= 1'b0;
      plan_left    <= 1'b0;
      plan_write   <= 1'b0;
      plan_read    <= 1'b0;
      plan_status  <= ST_OK;
      rd_cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            cap          <= cfg_wdata;
            first_count  <= '0;
            second_count <= '0;
            middle_count <= '0;
            middle_base  <= eff_of(cfg_wdata) >> 1;
          end else if (accept) begin
            first_count  <= first_next;
            second_count <= second_next;
            middle_count <= middle_next;
            middle_base  <= base_next;
            plan_shift   <= shift_next;
            plan_left    <= left_next;
            plan_write   <= write_next;
            plan_read    <= read_next;
            plan_status  <= status_next;
            rd_cnt       <= '0;
            if (shift_next) begin
              state <= S_SHIFT;
            end else if (write_next) begin
              state <= S_WRITE;
            end else if (read_next) begin
              state <= S_READ;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_RESP;
        end
        S_READ: begin
          if (rd_cnt == plan_raddr) begin
            state <= S_RESP;
          end else begin
            rd_cnt <= rd_cnt + CW'(1);
          end
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload part of the plan needs no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      plan_lo    <= lo_next;
      plan_end   <= end_next;
      plan_waddr <= waddr_next;
      plan_raddr <= raddr_next;
      plan_word  <= WORD_BITS'(req.push_value);
    end
  end

  assign ctrl.shift      = (state == S_SHIFT) && plan_shift;
  assign ctrl.shift_left = plan_left;
  assign ctrl.write      = (state == S_WRITE) && plan_write;
  assign ctrl.read       = (state == S_READ);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w, carry_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
      assign carry_w = '0;
    end else begin : g_inner_r
      assign right_w = words[i+1];
      assign carry_w = carries[i+1];
    end
    tss_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .shift_lo   (plan_lo),
      .shift_end  (plan_end),
      .waddr      (plan_waddr),
      .raddr      (plan_raddr),
      .wdata      (plan_word),
      .left_word  (left_w),
      .right_word (right_w),
      .carry_in   (carry_w),
      .word       (words[i]),
      .carry      (carries[i])
    );
  end

  assign req.ready     = (state == S_IDLE) && !cfg_we;
  assign rsp.valid     = (state == S_RESP);
  assign rsp.pop_value = plan_read ? VALUE_BITS'(carries[0]) : '0;
  assign rsp.status    = plan_status;

endmodule
